// ----- rtl/cca_pkg.sv -----
package cca_pkg;

    localparam int BIT_W  = 4;
    localparam int WORD_W = 16;

    localparam logic [2:0] ST_GRANTED       = 3'd0;
    localparam logic [2:0] ST_INSUFFICIENT  = 3'd1;
    localparam logic [2:0] ST_FREED         = 3'd2;
    localparam logic [2:0] ST_NOT_ALLOCATED = 3'd3;
    localparam logic [2:0] ST_BAD           = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;

    typedef struct packed {
        logic       action;
        logic [6:0] request_count;
        logic [8:0] minimum_cells;
        logic [7:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] granted_cell;
        logic       last;
        logic [8:0] free_cells;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_BAD    = 2'd2,
        CMD_NOFREE = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [6:0] count;
        logic [8:0] minimum;
        logic [7:0] cell_idx;
    } cmd_t;

endpackage

// ----- rtl/cca_front.sv -----
module cca_front #(
    parameter int CELLS     = 256,
    parameter int MAX_GRANT = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cca_pkg::in_item_t s_item,
    output logic              f_valid,
    input  logic              f_ready,
    output cca_pkg::cmd_t     f_cmd
);
    import cca_pkg::*;

    localparam int FCW   = $clog2(CELLS + 1);
    localparam int IDX_W = (FCW > 8) ? FCW : 8;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    always_comb begin
        cmd_next          = cmd_reg;
        cmd_next.count    = (s_item.request_count > 7'(MAX_GRANT)) ?
                            7'(MAX_GRANT) : s_item.request_count;
        cmd_next.minimum  = s_item.minimum_cells;
        cmd_next.cell_idx = s_item.cell_index;
        if (s_item.action == ACT_ALLOC) begin
            if (s_item.request_count == 7'd0 || s_item.minimum_cells == 9'd0) begin
                cmd_next.kind = CMD_BAD;
            end else begin
                cmd_next.kind = CMD_ALLOC;
            end
        end else if (IDX_W'(s_item.cell_index) < IDX_W'(CELLS)) begin
            cmd_next.kind = CMD_FREE;
        end else begin
            cmd_next.kind = CMD_NOFREE;
        end
    end

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_cmd   = cmd_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ----- rtl/cca_queue.sv -----
module cca_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  cca_pkg::cmd_t in_cmd,
    output logic          q_valid,
    input  logic          q_pop,
    output cca_pkg::cmd_t q_cmd
);
    import cca_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/cca_back.sv -----
module cca_back #(
    parameter int CELLS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  cca_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output cca_pkg::out_item_t m_item
);
    import cca_pkg::*;

    localparam int FCW    = $clog2(CELLS + 1);
    localparam int ROWS   = (CELLS + WORD_W - 1) / WORD_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CMP_W  = (FCW > 9) ? FCW : 9;
    localparam int PAD_W  = ROW_AW + BIT_W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_SCAN = 4'b0100,
        S_FCHK = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [ROW_AW-1:0]   row_reg;
    logic [ROW_AW-1:0]   row_next;
    logic [BIT_W-1:0]    bit_reg;
    logic [BIT_W-1:0]    bit_next;
    logic [6:0]          rem_reg;
    logic [6:0]          rem_next;
    logic [FCW-1:0]      fc_reg;
    logic [FCW-1:0]      fc_next;
    logic                is_free_reg;
    logic                is_free_next;
    logic                fresh_reg;
    logic                fresh_next;
    logic [WORD_W-1:0]   word_reg;
    logic [WORD_W-1:0]   word_next;
    logic [ROWS-1:0]     row_valid_reg;
    logic [ROWS-1:0]     row_valid_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    out_item_t           m_item_reg;
    out_item_t           m_item_next;

    logic [WORD_W-1:0]   mem [ROWS];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                rvalid_reg;
    logic                mem_we;
    logic [WORD_W-1:0]   mem_wdata;

    logic [WORD_W-1:0]   pad;
    logic [WORD_W-1:0]   eff;
    logic [WORD_W-1:0]   word_cur;
    logic [BIT_W-1:0]    sel;
    logic                any_free;
    logic                slot;
    logic                emit;
    logic                last_grant;
    logic [FCW-1:0]      fc_dec;
    logic [FCW-1:0]      fc_inc;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign slot    = !m_valid_reg || m_ready;
    assign fc_dec  = fc_reg - FCW'(1);
    assign fc_inc  = fc_reg + FCW'(1);

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            pad[b] = ({1'b0, row_reg, BIT_W'(b)} >= PAD_W'(CELLS));
        end
        eff      = (rvalid_reg ? rd_data_reg : '0) | pad;
        word_cur = fresh_reg ? eff : word_reg;
        any_free = !(&word_cur);
        sel      = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!word_cur[b]) begin
                sel = BIT_W'(b);
            end
        end
        last_grant = (rem_reg == 7'd1) || (fc_reg == FCW'(1));
    end

    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        fc_next        = fc_reg;
        is_free_next   = is_free_reg;
        fresh_next     = fresh_reg;
        word_next      = word_reg;
        row_valid_next = row_valid_reg;
        m_item_next    = m_item_reg;
        emit           = 1'b0;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_wdata      = word_cur;

        case (state_reg)
            S_IDLE: begin
                if (q_valid && slot) begin
                    q_pop                   = 1'b1;
                    m_item_next.last        = 1'b1;
                    m_item_next.free_cells  = 9'(fc_reg);
                    m_item_next.granted_cell = 8'd0;
                    case (q_cmd.kind)
                        CMD_BAD: begin
                            emit               = 1'b1;
                            m_item_next.status = ST_BAD;
                        end
                        CMD_NOFREE: begin
                            emit                     = 1'b1;
                            m_item_next.status       = ST_NOT_ALLOCATED;
                            m_item_next.granted_cell = q_cmd.cell_idx;
                        end
                        CMD_FREE: begin
                            row_next     = ROW_AW'(q_cmd.cell_idx >> BIT_W);
                            bit_next     = q_cmd.cell_idx[BIT_W-1:0];
                            is_free_next = 1'b1;
                            state_next   = S_RD;
                        end
                        CMD_ALLOC: begin
                            if (CMP_W'(q_cmd.minimum) > CMP_W'(fc_reg)) begin
                                emit               = 1'b1;
                                m_item_next.status = ST_INSUFFICIENT;
                            end else begin
                                rem_next     = q_cmd.count;
                                row_next     = '0;
                                is_free_next = 1'b0;
                                state_next   = S_RD;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                fresh_next = 1'b1;
                state_next = is_free_reg ? S_FCHK : S_SCAN;
            end
            S_SCAN: begin
                if (!any_free) begin
                    row_next   = row_reg + ROW_AW'(1);
                    state_next = S_RD;
                end else if (slot) begin
                    mem_we                   = 1'b1;
                    mem_wdata                = word_cur | (WORD_W'(1) << sel);
                    word_next                = mem_wdata;
                    fresh_next               = 1'b0;
                    fc_next                  = fc_dec;
                    rem_next                 = rem_reg - 7'd1;
                    emit                     = 1'b1;
                    m_item_next.status       = ST_GRANTED;
                    m_item_next.granted_cell = 8'({row_reg, sel});
                    m_item_next.last         = last_grant;
                    m_item_next.free_cells   = 9'(fc_dec);
                    if (last_grant) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FCHK: begin
                if (slot) begin
                    emit                     = 1'b1;
                    m_item_next.granted_cell = 8'({row_reg, bit_reg});
                    m_item_next.last         = 1'b1;
                    state_next               = S_IDLE;
                    if (word_cur[bit_reg]) begin
                        mem_we                 = 1'b1;
                        mem_wdata              = word_cur & ~(WORD_W'(1) << bit_reg);
                        fc_next                = fc_inc;
                        m_item_next.status     = ST_FREED;
                        m_item_next.free_cells = 9'(fc_inc);
                    end else begin
                        m_item_next.status     = ST_NOT_ALLOCATED;
                        m_item_next.free_cells = 9'(fc_reg);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (mem_we) begin
            row_valid_next[row_reg] = 1'b1;
        end
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[row_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[row_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fc_reg        <= FCW'(CELLS);
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fc_reg        <= fc_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        rvalid_reg  <= row_valid_reg[row_reg];
        row_reg     <= row_next;
        bit_reg     <= bit_next;
        rem_reg     <= rem_next;
        is_free_reg <= is_free_next;
        fresh_reg   <= fresh_next;
        word_reg    <= word_next;
        m_item_reg  <= m_item_next;
    end

endmodule

// ----- rtl/colour_cell_allocator.sv -----
// Channel  Ports                      Carries
// input    s_valid s_ready s_item     one allocate or free request
// result   m_valid m_ready m_item     one result; last marks the end of a request
//
// A request passes a register and a two-entry queue before it reaches the sequencer.
// Sequencer steps: a free reads a row, then checks the bit; an allocate reads, then scans
// each bitmap row of 16 cells it visits via the single read port, one grant per cycle
// unless stalled. Bad and insufficient requests read no row; each result is registered once.
// No clearing pass after reset: per-row valid flags read unwritten rows as free.
// A stalled result holds the sequencer; the queue keeps taking requests until it is full.
module colour_cell_allocator #(
    parameter int CELLS     = 256,
    parameter int MAX_GRANT = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cca_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output cca_pkg::out_item_t m_item
);
    import cca_pkg::*;

    logic f_valid;
    logic q_ready;
    cmd_t f_cmd;
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    cca_front #(
        .CELLS     (CELLS),
        .MAX_GRANT (MAX_GRANT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .f_valid (f_valid),
        .f_ready (q_ready),
        .f_cmd   (f_cmd)
    );

    cca_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (q_ready),
        .in_cmd   (f_cmd),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    cca_back #(
        .CELLS (CELLS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    a_single_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != ST_GRANTED |-> m_item.last)
        else $error("non-grant result without last");

    a_unused_cell : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == ST_INSUFFICIENT || m_item.status == ST_BAD)
        |-> m_item.granted_cell == 8'd0)
        else $error("granted_cell not zero on rejected request");

    a_queue_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_pop |=> q_valid)
        else $error("queue lost an item without a pop");

    a_front_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid && !q_ready |=> f_valid && $stable(f_cmd))
        else $error("front dropped a stalled item");

endmodule
